@@ rtl/pwbr_pkg.sv @@
// shared types and constants of the pulse width byte receiver
package pwbr_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 4;

  localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_SAT     = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd4;

  // configuration reset values
  localparam logic [TIME_W-1:0] SYNC_MIN_RST = 32'd2400;
  localparam logic [TIME_W-1:0] SYNC_MAX_RST = 32'd7200;
  localparam logic [TIME_W-1:0] ZERO_MAX_RST = 32'd12000;
  localparam logic [TIME_W-1:0] ONE_MAX_RST  = 32'd19200;

  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_SYNC = 2'd1,
    SYM_ZERO = 2'd2,
    SYM_ONE  = 2'd3
  } sym_t;

  // symbol request from the front part into the queue
  typedef struct packed {
    logic push;
    sym_t sym;
  } sym_push_t;

  // head of the queue as seen by the back part
  typedef struct packed {
    logic avail;
    sym_t sym;
  } sym_head_t;

endpackage

@@ rtl/pwbr_front.sv @@
// front part: config registers, edge pairing, pulse width and classification
module pwbr_front import pwbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 line_level,
  input  logic [TIME_W-1:0]    edge_time,
  input  logic                 q_full,
  output sym_push_t            push
);

  logic [TIME_W-1:0] sync_min;
  logic [TIME_W-1:0] sync_max;
  logic [TIME_W-1:0] zero_max;
  logic [TIME_W-1:0] one_max;
  logic              invert;

  logic              primed;
  logic              last_high;
  logic [TIME_W-1:0] rise_time;
  logic [TIME_W-1:0] width;
  logic              width_valid;

  logic level;
  logic accept;
  logic measure;
  logic drain;
  sym_t sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min <= SYNC_MIN_RST;
      sync_max <= SYNC_MAX_RST;
      zero_max <= ZERO_MAX_RST;
      one_max  <= ONE_MAX_RST;
      invert   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_MIN: sync_min <= cfg_data;
        REG_SYNC_MAX: sync_max <= cfg_data;
        REG_ZERO_MAX: zero_max <= cfg_data;
        REG_ONE_MAX:  one_max  <= cfg_data;
        REG_INVERT:   invert   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign level   = line_level ^ invert;
  assign accept  = in_valid && in_ready;
  // falling edge after a recorded rise closes a high pulse
  assign measure = !level && primed && last_high;

  // thresholds tested in fixed priority order
  always_comb begin
    if (width < sync_min) begin
      sym = SYM_NONE;
    end else if (width <= sync_max) begin
      sym = SYM_SYNC;
    end else if (width <= zero_max) begin
      sym = SYM_ZERO;
    end else if (width <= one_max) begin
      sym = SYM_ONE;
    end else begin
      sym = SYM_NONE;
    end
  end

  assign drain     = width_valid && ((sym == SYM_NONE) || !q_full);
  assign in_ready  = !width_valid || drain;
  assign push.push = width_valid && (sym != SYM_NONE) && !q_full;
  assign push.sym  = sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed      <= 1'b0;
      last_high   <= 1'b0;
      rise_time   <= '0;
      width_valid <= 1'b0;
    end else begin
      if (accept && measure) begin
        width_valid <= 1'b1;
      end else if (drain) begin
        width_valid <= 1'b0;
      end
      if (accept) begin
        if (level) begin
          if (!last_high) begin
            primed    <= 1'b1;
            rise_time <= edge_time;
            last_high <= 1'b1;
          end
        end else begin
          primed    <= 1'b1;
          last_high <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && measure) begin
      width <= edge_time - rise_time;
    end
  end

endmodule

@@ rtl/pwbr_queue.sv @@
// short symbol queue between front and back parts
module pwbr_queue import pwbr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  sym_push_t push,
  output logic      full,
  output sym_head_t head,
  input  logic      pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sym_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.avail = (count != '0);
  assign head.sym   = store[rd_ptr];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push.push && full))
    else $error("symbol pushed into full queue");

  a_pop_drops_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule

@@ rtl/pwbr_back.sv @@
// back part: bit shifter, bit counter and output register
module pwbr_back import pwbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sym_head_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] data_byte,
  output logic              malformed
);

  logic [BYTE_W-1:0]  shift_byte;
  logic [COUNT_W-1:0] bit_count;
  logic               emit;

  assign pop  = head.avail && (!out_valid || out_ready);
  assign emit = pop && (head.sym == SYM_SYNC) && (bit_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= '0;
      bit_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head.sym)
          SYM_SYNC: begin
            shift_byte <= '0;
            bit_count  <= '0;
          end
          SYM_ZERO, SYM_ONE: begin
            if (bit_count < BITS_PER_BYTE) begin
              shift_byte <= {shift_byte[BYTE_W-2:0], head.sym == SYM_ONE};
            end
            if (bit_count < COUNT_SAT) begin
              bit_count <= bit_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_byte <= shift_byte;
      malformed <= (bit_count != BITS_PER_BYTE);
    end
  end

`ifndef SYNTH
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    bit_count <= COUNT_SAT)
    else $error("bit count past saturation");

  a_sync_emits_byte: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && (data_byte == $past(shift_byte))))
    else $error("sync with bits did not present the byte");

  a_one_shifts_in: assert property (@(posedge clk) disable iff (rst)
    (pop && (head.sym == SYM_ONE) && (bit_count < BITS_PER_BYTE)) |=> shift_byte[0])
    else $error("one bit not shifted into byte");
`endif

endmodule

@@ rtl/pulse_width_byte_receiver_unit.sv @@
// top level of the pulse width byte receiver
// usage:
//   in channel (in_valid/in_ready) takes one line edge request per cycle
//   while in_ready is high: line_level and the free-running edge_time. high
//   pulse widths sort into noise, sync, zero, one or too long; zero/one bits
//   shift into a byte msb first and a sync after at least one bit delivers it.
//   out channel (out_valid/out_ready) carries data_byte and malformed, the
//   latter set when the bit count before the sync was not eight.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   thresholds and the line invert bit; cfg_ready is always high.
// timing:
//   one edge accepted every cycle while in_ready is high. a closing edge
//   passes the width register, is classified into the queue, then the
//   shifter loads the output register.
// reset:
//   thresholds return to 2400/7200/12000/19200, invert off, unprimed, queue
//   empty, byte and count cleared.
// stalls:
//   a held output stops the shifter; the symbol queue (QUEUE_DEPTH entries)
//   absorbs symbols until full, then in_ready drops on the next symbol
module pulse_width_byte_receiver_unit import pwbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 line_level,
  input  logic [TIME_W-1:0]    edge_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    data_byte,
  output logic                 malformed
);

  sym_push_t push;
  sym_head_t head;
  logic      q_full;
  logic      pop;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  pwbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .line_level (line_level),
    .edge_time  (edge_time),
    .q_full     (q_full),
    .push       (push)
  );

  // decouples classification from byte assembly
  pwbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  pwbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .malformed (malformed)
  );

endmodule
